>>> src/sale_pkg.sv
// sale_pkg: types and constants shared by the sensor alarm latch evaluator
// used by sale_front, sale_fifo, sale_back and sensor_alarm_latch_evaluator
package sale_pkg;

    localparam int NUM_FLAGS = 6;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int Q_CW      = $clog2(Q_DEPTH + 1);

    // gas ohms to kilohms: x / 1000 == (x * GAS_MAGIC) >> GAS_SHIFT for any 32-bit x
    localparam logic [28:0] GAS_MAGIC   = 29'd274877907;
    localparam int          GAS_SHIFT   = 38;
    localparam logic [31:0] GAS_SAT_OHM = 32'd32767000;
    localparam logic [15:0] GAS_SAT_K   = 16'd32767;

    // flag bit positions
    localparam int FL_THI = 0;
    localparam int FL_TLO = 1;
    localparam int FL_HUM = 2;
    localparam int FL_GAS = 3;
    localparam int FL_BAT = 4;
    localparam int FL_FLT = 5;

    typedef enum logic [2:0] {
        CFG_TEMP_HIGH = 3'd0,
        CFG_TEMP_LOW  = 3'd1,
        CFG_HUM_HIGH  = 3'd2,
        CFG_GAS_LOW   = 3'd3,
        CFG_BAT_LOW   = 3'd4,
        CFG_BAT_HYST  = 3'd5,
        CFG_EXPECTED  = 3'd6
    } t_cfg_addr;

    typedef enum logic [2:0] {
        KIND_NONE      = 3'd0,
        KIND_TEMP_HIGH = 3'd1,
        KIND_TEMP_LOW  = 3'd2,
        KIND_HUM_HIGH  = 3'd3,
        KIND_GAS_LOW   = 3'd4,
        KIND_BAT_LOW   = 3'd5,
        KIND_FAULT     = 3'd6
    } t_kind;

    localparam logic SEV_ALARM   = 1'b0;
    localparam logic SEV_WARNING = 1'b1;

    typedef struct packed {
        logic [2:0]         valid_bits;
        logic signed [15:0] temperature;
        logic [15:0]        humidity;
        logic [31:0]        gas_resistance;
        logic [15:0]        battery_voltage;
    } t_sample;

    typedef struct packed {
        t_kind              event_kind;
        logic               severity;
        logic signed [15:0] event_value;
        logic [5:0]         latched_flags;
        logic               last;
    } t_result;

    // classified sample handed from front to back
    typedef struct packed {
        logic [NUM_FLAGS-1:0] ev_mask;
        logic [NUM_FLAGS-1:0] flags;
        logic [2:0]           valid_bits;
        logic [15:0]          temperature;
        logic [15:0]          humidity;
        logic [15:0]          gas_k;
        logic [15:0]          battery;
    } t_entry;

endpackage

>>> src/sensor_alarm_latch_evaluator.sv
// Sensor alarm latch evaluator: accepts one request per cycle while the internal queue has room
// and gives one result per cycle while results are popped. A request yields one to MAX_EVENTS
// results (one for each alarm flag it newly sets, in order temperature, humidity, gas, battery,
// fault, or a single none result); later requests wait in the queue while the single result
// register of the back sequencer is busy. Requests pass the queue, then the result register.
// Depends on sale_pkg, sale_front, sale_fifo and sale_back.
module sensor_alarm_latch_evaluator #(
    parameter int MAX_EVENTS = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  sale_pkg::t_sample i_item,
    output logic              empty,
    input  logic              pop,
    output sale_pkg::t_result o_result,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_addr,
    input  logic [31:0]       i_cfg_wdata
);
    import sale_pkg::*;

    logic   accept;
    t_entry entry;
    t_entry head;
    logic   q_empty;
    logic   head_pop;

    sale_front #(
        .MAX_EVENTS (MAX_EVENTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_accept    (accept),
        .o_entry     (entry)
    );

    sale_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_data  (entry),
        .i_rd    (head_pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (q_empty)
    );

    sale_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (!q_empty),
        .o_head_pop   (head_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (o_result)
    );

endmodule

>>> src/sale_front.sv
// sale_front: configuration registers, latched alarm flags and sample classification
// depends on sale_pkg
module sale_front #(
    parameter int MAX_EVENTS = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_full,
    input  sale_pkg::t_sample i_item,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_addr,
    input  logic [31:0]       i_cfg_wdata,
    output logic              o_accept,
    output sale_pkg::t_entry  o_entry
);
    import sale_pkg::*;

    logic signed [15:0]   r_thi;
    logic signed [15:0]   r_tlo;
    logic [15:0]          r_hum;
    logic [31:0]          r_gas;
    logic [15:0]          r_bat;
    logic [15:0]          r_hys;
    logic [2:0]           r_exp;
    logic [NUM_FLAGS-1:0] r_latched;

    logic [NUM_FLAGS-1:0] n_latched;
    logic [NUM_FLAGS-1:0] ev_raw;
    logic [NUM_FLAGS-1:0] ev_kept;
    logic [2:0]           ev_cnt;
    logic [15:0]          bat_clr;
    logic [60:0]          gas_prod;
    logic [15:0]          gas_k;

    assign o_accept = i_push && !i_full;
    assign bat_clr  = r_bat + r_hys;
    assign gas_prod = i_item.gas_resistance * GAS_MAGIC;
    assign gas_k    = (i_item.gas_resistance >= GAS_SAT_OHM) ? GAS_SAT_K
                                                             : gas_prod[GAS_SHIFT +: 16];

    always_comb begin
        n_latched = r_latched;
        ev_raw    = '0;
        if (i_item.valid_bits[0]) begin
            if (i_item.temperature > r_thi) begin
                if (!n_latched[FL_THI]) begin
                    n_latched[FL_THI] = 1'b1;
                    ev_raw[FL_THI]    = 1'b1;
                end
            end else if (i_item.temperature < r_tlo) begin
                if (!n_latched[FL_TLO]) begin
                    n_latched[FL_TLO] = 1'b1;
                    ev_raw[FL_TLO]    = 1'b1;
                end
            end else begin
                n_latched[FL_THI] = 1'b0;
                n_latched[FL_TLO] = 1'b0;
            end
            if (i_item.humidity > r_hum) begin
                if (!n_latched[FL_HUM]) begin
                    n_latched[FL_HUM] = 1'b1;
                    ev_raw[FL_HUM]    = 1'b1;
                end
            end else begin
                n_latched[FL_HUM] = 1'b0;
            end
        end
        if (i_item.valid_bits[1] && (r_gas != '0)) begin
            if (i_item.gas_resistance < r_gas) begin
                if (!n_latched[FL_GAS]) begin
                    n_latched[FL_GAS] = 1'b1;
                    ev_raw[FL_GAS]    = 1'b1;
                end
            end else begin
                n_latched[FL_GAS] = 1'b0;
            end
        end
        if (i_item.valid_bits[2]) begin
            if (i_item.battery_voltage < r_bat) begin
                if (!n_latched[FL_BAT]) begin
                    n_latched[FL_BAT] = 1'b1;
                    ev_raw[FL_BAT]    = 1'b1;
                end
            end else if (i_item.battery_voltage >= bat_clr) begin
                n_latched[FL_BAT] = 1'b0;
            end
        end
        if ((i_item.valid_bits & r_exp) != r_exp) begin
            if (!n_latched[FL_FLT]) begin
                n_latched[FL_FLT] = 1'b1;
                ev_raw[FL_FLT]    = 1'b1;
            end
        end else begin
            n_latched[FL_FLT] = 1'b0;
        end
    end

    // keep only the first MAX_EVENTS events in flag order
    always_comb begin
        ev_kept = '0;
        ev_cnt  = '0;
        for (int i = 0; i < NUM_FLAGS; i++) begin
            if (ev_raw[i] && (ev_cnt < 3'(MAX_EVENTS))) begin
                ev_kept[i] = 1'b1;
                ev_cnt     = ev_cnt + 3'd1;
            end
        end
    end

    always_comb begin
        o_entry.ev_mask     = ev_kept;
        o_entry.flags       = n_latched;
        o_entry.valid_bits  = i_item.valid_bits;
        o_entry.temperature = i_item.temperature;
        o_entry.humidity    = i_item.humidity;
        o_entry.gas_k       = gas_k;
        o_entry.battery     = i_item.battery_voltage;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched <= '0;
        end else if (o_accept) begin
            r_latched <= n_latched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thi <= 16'sd3500;
            r_tlo <= 16'sd0;
            r_hum <= 16'd8000;
            r_gas <= 32'd0;
            r_bat <= 16'd2200;
            r_hys <= 16'd100;
            r_exp <= 3'd7;
        end else if (i_cfg_we) begin
            case (t_cfg_addr'(i_cfg_addr))
                CFG_TEMP_HIGH: r_thi <= i_cfg_wdata[15:0];
                CFG_TEMP_LOW:  r_tlo <= i_cfg_wdata[15:0];
                CFG_HUM_HIGH:  r_hum <= i_cfg_wdata[15:0];
                CFG_GAS_LOW:   r_gas <= i_cfg_wdata;
                CFG_BAT_LOW:   r_bat <= i_cfg_wdata[15:0];
                CFG_BAT_HYST:  r_hys <= i_cfg_wdata[15:0];
                CFG_EXPECTED:  r_exp <= i_cfg_wdata[2:0];
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_events_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_accept |-> ((o_entry.ev_mask & ~o_entry.flags) == '0))
        else $error("event raised for a flag that is not set");

    a_flags_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_accept |=> (r_latched == $past(n_latched)))
        else $error("latched flags not updated on request");
`endif

endmodule

>>> src/sale_fifo.sv
// sale_fifo: short register queue between the classifying front and the event back
// depends on sale_pkg
module sale_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  sale_pkg::t_entry i_data,
    input  logic             i_rd,
    output sale_pkg::t_entry o_head,
    output logic             o_full,
    output logic             o_empty
);
    import sale_pkg::*;

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;

    logic do_wr;
    logic do_rd;

    assign o_full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CW'(Q_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

>>> src/sale_back.sv
// sale_back: walks the event mask of the head entry, one result per cycle, into the output register;
// it stalls while that register holds a result that is not popped, and depends on sale_pkg
module sale_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sale_pkg::t_entry  i_head,
    input  logic              i_head_valid,
    output logic              o_head_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output sale_pkg::t_result o_result
);
    import sale_pkg::*;

    logic                 r_out_valid;
    t_result              r_out;
    logic [NUM_FLAGS-1:0] r_done;

    logic [NUM_FLAGS-1:0] pend;
    logic [NUM_FLAGS-1:0] sel;
    logic [2:0]           idx;
    logic                 is_last;
    logic                 load;
    t_result              n_out;

    assign pend    = i_head.ev_mask & ~r_done;
    assign sel     = pend & (~pend + 1'b1);
    assign is_last = ((pend & ~sel) == '0);
    assign load    = i_head_valid && (!r_out_valid || i_pop);

    assign o_head_pop = load && is_last;
    assign o_empty    = !r_out_valid;
    assign o_result   = r_out;

    always_comb begin
        idx = '0;
        for (int i = NUM_FLAGS - 1; i >= 0; i--) begin
            if (pend[i]) begin
                idx = 3'(i);
            end
        end
    end

    always_comb begin
        n_out.latched_flags = i_head.flags;
        n_out.last          = is_last;
        n_out.event_kind    = KIND_NONE;
        n_out.severity      = SEV_ALARM;
        n_out.event_value   = '0;
        if (pend != '0) begin
            case (idx)
                3'(FL_THI): begin
                    n_out.event_kind  = KIND_TEMP_HIGH;
                    n_out.event_value = i_head.temperature;
                end
                3'(FL_TLO): begin
                    n_out.event_kind  = KIND_TEMP_LOW;
                    n_out.event_value = i_head.temperature;
                end
                3'(FL_HUM): begin
                    n_out.event_kind  = KIND_HUM_HIGH;
                    n_out.severity    = SEV_WARNING;
                    n_out.event_value = i_head.humidity;
                end
                3'(FL_GAS): begin
                    n_out.event_kind  = KIND_GAS_LOW;
                    n_out.severity    = SEV_WARNING;
                    n_out.event_value = i_head.gas_k;
                end
                3'(FL_BAT): begin
                    n_out.event_kind  = KIND_BAT_LOW;
                    n_out.severity    = SEV_WARNING;
                    n_out.event_value = i_head.battery;
                end
                3'(FL_FLT): begin
                    n_out.event_kind  = KIND_FAULT;
                    n_out.severity    = SEV_WARNING;
                    n_out.event_value = {13'd0, i_head.valid_bits};
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_done      <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_done      <= is_last ? '0 : (r_done | sel);
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_done_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> ((r_done & ~i_head.ev_mask) == '0))
        else $error("emitted bits outside the head event mask");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_head_pop |=> (r_done == '0))
        else $error("progress mask not cleared after final result");
`endif

endmodule

>>> tb/testbench.sv
// testbench for sensor_alarm_latch_evaluator: a directed table of samples and register writes,
// then random thresholds with random samples, each result checked against the table or a predictor
// depends on sale_pkg and the sensor_alarm_latch_evaluator rtl
module testbench;
    import sale_pkg::*;

    localparam int MAX_EVENTS  = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 27;
    localparam int PRINT_LIMIT = 50;

    typedef struct {
        logic        is_cfg;
        t_cfg_addr   addr;
        logic [31:0] data;
        t_sample     smp;
        logic        typed;
        t_result     res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_sample     i_item;
    logic        empty;
    logic        pop;
    t_result     o_result;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [31:0] i_cfg_wdata;

    logic signed [15:0] lim_temp_high;
    logic signed [15:0] lim_temp_low;
    logic [15:0]        lim_hum;
    logic [31:0]        lim_gas;
    logic [15:0]        lim_bat;
    logic [15:0]        lim_hys;
    logic [2:0]         lim_exp;
    logic [5:0]         latched;

    t_result alarms_due[$];
    t_result predicted[MAX_EVENTS];
    t_row    plan[$];

    int errors;
    int samples_sent;
    int results_checked;
    int settings_used;
    int snd_idle;
    int rcv_idle;
    int cycles;

    sensor_alarm_latch_evaluator #(
        .MAX_EVENTS(MAX_EVENTS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("mismatch %0d at cycle %0d: %s got %0h expected %0h",
                     errors, cycles, what, got, want);
    endtask

    function automatic void add_alarm_event(inout int n, input t_kind k, input logic sev,
                                            input logic [15:0] v);
        if (n < MAX_EVENTS) begin
            predicted[n].event_kind  = k;
            predicted[n].severity    = sev;
            predicted[n].event_value = v;
            n++;
        end
    endfunction

    function automatic int evaluate_sample(t_sample s);
        logic [5:0]  f;
        logic [15:0] clr;
        logic [31:0] kilo;
        int          n;
        f = latched;
        n = 0;
        if (s.valid_bits[0]) begin
            if (s.temperature > lim_temp_high) begin
                if (!f[FL_THI]) begin
                    f[FL_THI] = 1'b1;
                    add_alarm_event(n, KIND_TEMP_HIGH, SEV_ALARM, s.temperature);
                end
            end else if (s.temperature < lim_temp_low) begin
                if (!f[FL_TLO]) begin
                    f[FL_TLO] = 1'b1;
                    add_alarm_event(n, KIND_TEMP_LOW, SEV_ALARM, s.temperature);
                end
            end else begin
                f[FL_THI] = 1'b0;
                f[FL_TLO] = 1'b0;
            end
            if (s.humidity > lim_hum) begin
                if (!f[FL_HUM]) begin
                    f[FL_HUM] = 1'b1;
                    add_alarm_event(n, KIND_HUM_HIGH, SEV_WARNING, s.humidity);
                end
            end else begin
                f[FL_HUM] = 1'b0;
            end
        end
        if (s.valid_bits[1] && lim_gas != 32'd0) begin
            if (s.gas_resistance < lim_gas) begin
                if (!f[FL_GAS]) begin
                    kilo = s.gas_resistance / 32'd1000;
                    if (kilo > 32'd32767)
                        kilo = 32'd32767;
                    f[FL_GAS] = 1'b1;
                    add_alarm_event(n, KIND_GAS_LOW, SEV_WARNING, kilo[15:0]);
                end
            end else begin
                f[FL_GAS] = 1'b0;
            end
        end
        if (s.valid_bits[2]) begin
            clr = lim_bat + lim_hys;
            if (s.battery_voltage < lim_bat) begin
                if (!f[FL_BAT]) begin
                    f[FL_BAT] = 1'b1;
                    add_alarm_event(n, KIND_BAT_LOW, SEV_WARNING, s.battery_voltage);
                end
            end else if (s.battery_voltage >= clr) begin
                f[FL_BAT] = 1'b0;
            end
        end
        if ((s.valid_bits & lim_exp) != lim_exp) begin
            if (!f[FL_FLT]) begin
                f[FL_FLT] = 1'b1;
                add_alarm_event(n, KIND_FAULT, SEV_WARNING, {13'd0, s.valid_bits});
            end
        end else begin
            f[FL_FLT] = 1'b0;
        end
        latched = f;
        if (n == 0) begin
            predicted[0].event_kind  = KIND_NONE;
            predicted[0].severity    = SEV_ALARM;
            predicted[0].event_value = '0;
            n = 1;
        end
        for (int i = 0; i < n; i++) begin
            predicted[i].latched_flags = f;
            predicted[i].last          = (i == n - 1);
        end
        return n;
    endfunction

    function automatic t_sample mk_sample(logic [2:0] vb, logic [15:0] t, logic [15:0] h,
                                          logic [31:0] g, logic [15:0] b);
        t_sample s;
        s.valid_bits      = vb;
        s.temperature     = t;
        s.humidity        = h;
        s.gas_resistance  = g;
        s.battery_voltage = b;
        return s;
    endfunction

    function automatic t_result mk_result(t_kind k, logic sev, logic [15:0] v, logic [5:0] f);
        t_result r;
        r.event_kind    = k;
        r.severity      = sev;
        r.event_value   = v;
        r.latched_flags = f;
        r.last          = 1'b1;
        return r;
    endfunction

    function automatic logic [15:0] near16(logic [15:0] base);
        return base + 16'($urandom_range(0, 64)) - 16'd32;
    endfunction

    function automatic logic [31:0] near32(logic [31:0] base);
        return base + $urandom_range(0, 4000) - 32'd2000;
    endfunction

    function automatic t_sample random_sample();
        t_sample s;
        s.valid_bits = ($urandom_range(0, 3) != 0) ? 3'd7 : 3'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
            0: s.temperature = 16'($urandom);
            1: s.temperature = near16(lim_temp_high);
            2: s.temperature = near16(lim_temp_low);
            default: s.temperature = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        endcase
        case ($urandom_range(0, 3))
            0: s.humidity = 16'($urandom);
            3: s.humidity = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: s.humidity = near16(lim_hum);
        endcase
        case ($urandom_range(0, 3))
            0: s.gas_resistance = $urandom;
            3: s.gas_resistance = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: s.gas_resistance = near32(lim_gas);
        endcase
        case ($urandom_range(0, 4))
            0: s.battery_voltage = 16'($urandom);
            1: s.battery_voltage = near16(lim_bat);
            2: s.battery_voltage = near16(lim_bat + lim_hys);
            3: s.battery_voltage = near16(lim_bat + lim_hys);
            default: s.battery_voltage = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
        return s;
    endfunction

    task automatic add_cfg(t_cfg_addr a, logic [31:0] d);
        t_row r;
        r.is_cfg = 1'b1;
        r.addr   = a;
        r.data   = d;
        r.smp    = '0;
        r.typed  = 1'b0;
        r.res    = '0;
        plan.push_back(r);
    endtask

    task automatic add_smp(t_sample s);
        t_row r;
        r.is_cfg = 1'b0;
        r.addr   = CFG_TEMP_HIGH;
        r.data   = '0;
        r.smp    = s;
        r.typed  = 1'b0;
        r.res    = '0;
        plan.push_back(r);
    endtask

    task automatic add_known(t_sample s, t_result res);
        t_row r;
        r.is_cfg = 1'b0;
        r.addr   = CFG_TEMP_HIGH;
        r.data   = '0;
        r.smp    = s;
        r.typed  = 1'b1;
        r.res    = res;
        plan.push_back(r);
    endtask

    // lower the request and wait until every expected result has been taken
    task automatic settle();
        push     <= 1'b0;
        i_cfg_we <= 1'b0;
        do @(posedge i_clk); while (alarms_due.size() != 0);
    endtask

    task automatic write_reg(t_cfg_addr a, logic [31:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= a;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        case (a)
            CFG_TEMP_HIGH: lim_temp_high = d[15:0];
            CFG_TEMP_LOW:  lim_temp_low  = d[15:0];
            CFG_HUM_HIGH:  lim_hum       = d[15:0];
            CFG_GAS_LOW:   lim_gas       = d;
            CFG_BAT_LOW:   lim_bat       = d[15:0];
            CFG_BAT_HYST:  lim_hys       = d[15:0];
            CFG_EXPECTED:  lim_exp       = d[2:0];
            default: ;
        endcase
    endtask

    task automatic random_settings();
        logic [31:0] v;
        int          sel;
        settle();
        for (int a = 0; a < 7; a++) begin
            sel = $urandom_range(0, 3);
            v   = $urandom;
            case (t_cfg_addr'(a))
                CFG_TEMP_HIGH, CFG_TEMP_LOW: begin
                    if (sel == 0) v = 32'h8000;
                    else if (sel == 1) v = 32'h7FFF;
                end
                CFG_GAS_LOW: begin
                    if (sel == 0) v = 32'd0;
                    else if (sel == 1) v = 32'hFFFF_FFFF;
                    else v = $urandom_range(1000, 2000000);
                end
                CFG_EXPECTED: begin
                    if (sel == 0) v = 32'd0;
                    else if (sel == 1) v = 32'd7;
                    else v = $urandom_range(0, 7);
                end
                default: begin
                    if (sel == 0) v = 32'd0;
                    else if (sel == 1) v = 32'hFFFF;
                end
            endcase
            write_reg(t_cfg_addr'(a), v);
        end
        settings_used++;
    endtask

    task automatic send_sample(t_sample s, logic typed, t_result known);
        int n;
        i_cfg_we <= 1'b0;
        while ($urandom_range(0, 99) < snd_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= s;
        do @(posedge i_clk); while (full);
        n = evaluate_sample(s);
        if (typed) begin
            alarms_due.push_back(known);
        end else begin
            for (int i = 0; i < n; i++)
                alarms_due.push_back(predicted[i]);
        end
        samples_sent++;
    endtask

    initial begin
        t_result want;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (alarms_due.size() == 0) begin
                    report("result with no sample pending", o_result, '0);
                end else begin
                    want = alarms_due.pop_front();
                    results_checked++;
                    if (o_result.event_kind !== want.event_kind)
                        report("event_kind", o_result.event_kind, want.event_kind);
                    if (o_result.severity !== want.severity)
                        report("severity", o_result.severity, want.severity);
                    if (o_result.event_value !== want.event_value)
                        report("event_value", o_result.event_value, want.event_value);
                    if (o_result.latched_flags !== want.latched_flags)
                        report("latched_flags", o_result.latched_flags, want.latched_flags);
                    if (o_result.last !== want.last)
                        report("last", o_result.last, want.last);
                end
            end
            pop <= ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        lim_temp_high   = 16'sd3500;
        lim_temp_low    = 16'sd0;
        lim_hum         = 16'd8000;
        lim_gas         = 32'd0;
        lim_bat         = 16'd2200;
        lim_hys         = 16'd100;
        lim_exp         = 3'd7;
        latched         = '0;
        errors          = 0;
        samples_sent    = 0;
        results_checked = 0;
        settings_used   = 1;
        snd_idle        = 33;
        rcv_idle        = 54;
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_item      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= '0;
        i_cfg_wdata <= '0;

        // after reset, at default thresholds
        add_known(mk_sample(3'd7, 16'd2000, 16'd5000, 32'd100000, 16'd3000),
                  mk_result(KIND_NONE, SEV_ALARM, 16'h0000, 6'h00));
        add_known(mk_sample(3'd7, 16'h7FFF, 16'd5000, 32'd100000, 16'd3000),
                  mk_result(KIND_TEMP_HIGH, SEV_ALARM, 16'h7FFF, 6'h01));
        add_known(mk_sample(3'd7, 16'h8000, 16'd5000, 32'd100000, 16'd3000),
                  mk_result(KIND_TEMP_LOW, SEV_ALARM, 16'h8000, 6'h03));
        add_known(mk_sample(3'd0, 16'd2000, 16'd5000, 32'd100000, 16'd3000),
                  mk_result(KIND_FAULT, SEV_WARNING, 16'h0000, 6'h23));
        add_known(mk_sample(3'd7, 16'd2000, 16'hFFFF, 32'd100000, 16'd3000),
                  mk_result(KIND_HUM_HIGH, SEV_WARNING, 16'hFFFF, 6'h04));
        add_known(mk_sample(3'd7, 16'd2000, 16'd0, 32'd100000, 16'd0),
                  mk_result(KIND_BAT_LOW, SEV_WARNING, 16'h0000, 6'h10));
        // battery inside the hysteresis band holds, at the clear point it clears
        add_known(mk_sample(3'd7, 16'd2000, 16'd0, 32'd100000, 16'd2250),
                  mk_result(KIND_NONE, SEV_ALARM, 16'h0000, 6'h10));
        add_known(mk_sample(3'd7, 16'd2000, 16'd0, 32'd100000, 16'd2300),
                  mk_result(KIND_NONE, SEV_ALARM, 16'h0000, 6'h00));
        add_smp(mk_sample(3'd7, 16'd4000, 16'd9000, 32'd0, 16'd100));
        add_smp(mk_sample(3'd3, -16'sd100, 16'd100, 32'd0, 16'd100));
        // gas check enabled, kilohm saturation
        add_cfg(CFG_GAS_LOW, 32'hFFFF_FFFF);
        add_smp(mk_sample(3'd7, 16'd2000, 16'd0, 32'hFFFF_FFFF, 16'hFFFF));
        add_smp(mk_sample(3'd7, 16'd2000, 16'd0, 32'hFFFF_FFFE, 16'hFFFF));
        add_smp(mk_sample(3'd2, 16'd2000, 16'd0, 32'd999, 16'hFFFF));
        add_smp(mk_sample(3'd7, 16'd2000, 16'd0, 32'hFFFF_FFFF, 16'hFFFF));
        add_cfg(CFG_GAS_LOW, 32'd1000);
        add_smp(mk_sample(3'd7, 16'd2000, 16'd0, 32'd999, 16'hFFFF));
        // clear point wraps past 16 bits
        add_cfg(CFG_BAT_LOW, 32'd65500);
        add_cfg(CFG_BAT_HYST, 32'd100);
        add_smp(mk_sample(3'd4, 16'd2000, 16'd0, 32'd5000, 16'd65499));
        add_smp(mk_sample(3'd4, 16'd2000, 16'd0, 32'd5000, 16'd64));
        add_smp(mk_sample(3'd4, 16'd2000, 16'd0, 32'd5000, 16'd65500));
        // limits at the extremes
        add_cfg(CFG_TEMP_HIGH, 32'h7FFF);
        add_cfg(CFG_TEMP_LOW, 32'h8000);
        add_cfg(CFG_HUM_HIGH, 32'hFFFF);
        add_smp(mk_sample(3'd7, 16'h7FFF, 16'hFFFF, 32'd5000, 16'd0));
        add_cfg(CFG_EXPECTED, 32'd0);
        add_cfg(CFG_BAT_HYST, 32'd0);
        add_cfg(CFG_BAT_LOW, 32'd0);
        add_smp(mk_sample(3'd0, 16'd0, 16'd0, 32'd0, 16'd0));
        add_smp(mk_sample(3'd7, 16'd0, 16'd0, 32'd0, 16'd0));
        add_cfg(CFG_TEMP_HIGH, 32'h8000);
        add_cfg(CFG_TEMP_LOW, 32'h7FFF);
        add_smp(mk_sample(3'd7, 16'd0, 16'd0, 32'd5000, 16'd0));
        add_smp(mk_sample(3'd7, 16'h8000, 16'd0, 32'd5000, 16'd0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                settle();
                write_reg(plan[i].addr, plan[i].data);
            end else begin
                send_sample(plan[i].smp, plan[i].typed, plan[i].res);
            end
        end

        for (int mode = 0; mode < 3; mode++) begin
            snd_idle = (mode == 0) ? 33 : (mode == 1) ? 54 : 0;
            rcv_idle = (mode == 0) ? 54 : (mode == 1) ? 33 : 0;
            for (int phase = 0; phase < 3; phase++) begin
                random_settings();
                for (int n = 0; n < PHASE_ITEMS; n++) begin
                    if (mode == 0 && phase == 1 && n == PHASE_ITEMS / 2)
                        settle();
                    send_sample(random_sample(), 1'b0, '0);
                end
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (alarms_due.size() != 0)
            report("results never delivered", alarms_due.size(), 0);

        $display("sent %0d samples under %0d threshold settings, checked %0d alarm results",
                 samples_sent, settings_used, results_checked);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
